### hw/rtl/arwc_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// arwc_pkg
// Shared types and constants for the anti-replay window check core.
// -----------------------------------------------------------------------------
package arwc_pkg;

   localparam int WINDOW_SIZE = 64;   // 8 .. 64
   localparam int CTR_W       = 64;
   localparam int BIT_IDX_W   = 6;

   // Bitmap bits kept: the top WINDOW_SIZE bits, bit 63 is the highest counter.
   localparam logic [CTR_W-1:0] WINDOW_MASK = ~(CTR_W'(0)) << (CTR_W - WINDOW_SIZE);
   localparam logic [CTR_W-1:0] TOP_BIT     = CTR_W'(1) << (CTR_W - 1);
   localparam logic [CTR_W-1:0] WINDOW_LEN  = CTR_W'(WINDOW_SIZE);
   localparam logic [31:0]      MAX_LOST    = 32'(WINDOW_SIZE - 1);

   // Result status codes
   localparam logic [2:0] ST_NEW   = 3'd0;
   localparam logic [2:0] ST_LATE  = 3'd1;
   localparam logic [2:0] ST_SHORT = 3'd2;
   localparam logic [2:0] ST_OLD   = 3'd3;
   localparam logic [2:0] ST_DUP   = 3'd4;
   localparam logic [2:0] ST_AUTH  = 3'd5;

   // Configuration register indexes
   localparam logic CSR_ENABLE     = 1'b0;
   localparam logic CSR_MIN_LENGTH = 1'b1;

   localparam logic [7:0] MIN_LENGTH_RESET = 8'd28;

   typedef struct packed {
      logic [63:0] packet_counter;
      logic [15:0] packet_length;
      logic        auth_ok;
   } req_payload_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  status;
      logic [31:0] good_count;
      logic [31:0] late_count;
      logic [31:0] lost_count;
   } rsp_payload_type;

endpackage

### hw/rtl/anti_replay_window_check_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// anti_replay_window_check_core
// Sliding-window replay check of received packet counters with statistics.
// -----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per received packet (counter, length, auth verdict).
//   rsp_*  : one beat per packet with the verdict and the running totals.
//   csr_*  : write-only registers, index 0 enable, index 1 minimum length;
//            write them only while no packet is in flight.
// Throughput: one packet per cycle while rsp_stall is low. The window check,
//   state commit and result capture happen in one registered pass between
//   the input register and the result register, so the next packet sees
//   the updated window at once.
// Reset: the window, bitmap and totals clear, enable drops to 0 and the
//   minimum length returns to 28; both pipeline registers empty.
// Stall: a stalled result holds; the input register keeps taking a beat
//   while the result register is free, then req_stall rises until the
//   receiver takes the held result.
// -----------------------------------------------------------------------------
module anti_replay_window_check_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  arwc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output arwc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [7:0]                csr_wdata
);

   // configuration
   logic       enable_ff;
   logic [7:0] min_len_ff;

   // pipeline
   logic                      in_vld_ff;
   arwc_pkg::req_payload_type in_ff;
   logic                      out_vld_ff;
   arwc_pkg::rsp_payload_type out_ff;
   arwc_pkg::rsp_payload_type out_in;

   // window state
   logic [63:0] highest_ff, highest_in;
   logic [63:0] seen_ff, seen_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] late_ff, late_in;
   logic [31:0] lost_ff, lost_in;

   logic out_free;
   logic pass_fire;
   logic req_fire;

   logic [63:0]                    back_dist;
   logic [63:0]                    fwd_dist;
   logic [arwc_pkg::BIT_IDX_W-1:0] back_idx;
   logic [63:0]                    back_bit;
   logic                           behind;
   logic [2:0]                     status;
   logic                           commit;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign pass_fire = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

   // window check
   always_comb begin
      behind    = in_ff.packet_counter <= highest_ff;
      back_dist = highest_ff - in_ff.packet_counter;
      fwd_dist  = in_ff.packet_counter - highest_ff;
      back_idx  = 6'd63 - back_dist[arwc_pkg::BIT_IDX_W-1:0];
      back_bit  = 64'd1 << back_idx;

      highest_in = highest_ff;
      seen_in    = seen_ff;
      good_in    = good_ff;
      late_in    = late_ff;
      lost_in    = lost_ff;

      priority if (!enable_ff || (in_ff.packet_length < {8'd0, min_len_ff})) begin
         status = arwc_pkg::ST_SHORT;
      end else if (behind) begin
         if (back_dist >= arwc_pkg::WINDOW_LEN) begin
            status = arwc_pkg::ST_OLD;
         end else if (seen_ff[back_idx]) begin
            status = arwc_pkg::ST_DUP;
         end else begin
            status  = arwc_pkg::ST_LATE;
            seen_in = seen_ff | back_bit;
            late_in = late_ff + 32'd1;
         end
      end else begin
         status     = arwc_pkg::ST_NEW;
         highest_in = in_ff.packet_counter;
         good_in    = good_ff + 32'd1;
         if (fwd_dist >= arwc_pkg::WINDOW_LEN) begin
            // big jump: restart the window at the newest counter
            seen_in = arwc_pkg::TOP_BIT;
            lost_in = lost_ff + arwc_pkg::MAX_LOST;
         end else begin
            seen_in = ((seen_ff << fwd_dist[arwc_pkg::BIT_IDX_W-1:0]) | arwc_pkg::TOP_BIT)
                      & arwc_pkg::WINDOW_MASK;
            lost_in = lost_ff + (fwd_dist[31:0] - 32'd1);
         end
      end

      // auth failure drops an otherwise acceptable packet
      if ((status == arwc_pkg::ST_NEW || status == arwc_pkg::ST_LATE) && !in_ff.auth_ok) begin
         status = arwc_pkg::ST_AUTH;
      end

      commit = (status == arwc_pkg::ST_NEW) || (status == arwc_pkg::ST_LATE);

      if (!commit) begin
         highest_in = highest_ff;
         seen_in    = seen_ff;
         good_in    = good_ff;
         late_in    = late_ff;
         lost_in    = lost_ff;
      end

      out_in.accepted   = commit;
      out_in.status     = status;
      out_in.good_count = good_in;
      out_in.late_count = late_in;
      out_in.lost_count = lost_in;
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         min_len_ff <= arwc_pkg::MIN_LENGTH_RESET;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         highest_ff <= '0;
         seen_ff    <= '0;
         good_ff    <= '0;
         late_ff    <= '0;
         lost_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               arwc_pkg::CSR_ENABLE:     enable_ff  <= csr_wdata[0];
               arwc_pkg::CSR_MIN_LENGTH: min_len_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_fire) begin
            in_vld_ff <= 1'b1;
         end else if (pass_fire) begin
            in_vld_ff <= 1'b0;
         end
         if (pass_fire) begin
            out_vld_ff <= 1'b1;
            highest_ff <= highest_in;
            seen_ff    <= seen_in;
            good_ff    <= good_in;
            late_ff    <= late_in;
            lost_ff    <= lost_in;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_payload;
      end
      if (pass_fire) begin
         out_ff <= out_in;
      end
   end

   // checks
   a_accept_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.accepted ==
                     (rsp_payload.status == arwc_pkg::ST_NEW ||
                      rsp_payload.status == arwc_pkg::ST_LATE)))
      else $error("accepted flag disagrees with status");

   a_state_holds_on_reject: assert property (@(posedge clock) disable iff (reset)
      !(pass_fire && commit) |=> ($stable(highest_ff) && $stable(seen_ff) &&
                                  $stable(good_ff) && $stable(late_ff) && $stable(lost_ff)))
      else $error("window state changed without an accepted packet");

   a_newest_marked: assert property (@(posedge clock) disable iff (reset)
      (pass_fire && status == arwc_pkg::ST_NEW) |=> seen_ff[63])
      else $error("newest counter not marked in bitmap");

   a_bitmap_in_window: assert property (@(posedge clock) disable iff (reset)
      (seen_ff & ~arwc_pkg::WINDOW_MASK) == 64'd0)
      else $error("bitmap bit set outside the window");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff))
      else $error("input stalled with room in the pipeline");

endmodule

### dv/anti_replay_window_check_core_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// anti_replay_window_check_core_tb
// Self-checking bench for the replay window check core. A scoreboard predicts
// the verdict and running totals for every accepted packet beat and compares
// them with the result beats in order, while random idle, back-pressure and
// register settings (disabled, minimum length 0 and 255) are applied.
// -----------------------------------------------------------------------------
module anti_replay_window_check_core_tb;

   localparam int QUIET_LIMIT = 2000;

   // Predicts one result beat per packet and checks results in arrival order.
   class replay_scoreboard;
      logic        enable;
      logic [7:0]  min_length;
      logic [63:0] highest;
      logic [63:0] seen_map;
      logic [31:0] good_total;
      logic [31:0] late_total;
      logic [31:0] lost_total;
      arwc_pkg::rsp_payload_type expected_q[$];
      int mismatches;
      int results_checked;
      int status_hits[8];

      function new();
         enable     = 1'b0;
         min_length = arwc_pkg::MIN_LENGTH_RESET;
         highest    = '0;
         seen_map   = '0;
         good_total = '0;
         late_total = '0;
         lost_total = '0;
         mismatches = 0;
         results_checked = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      function void write_reg(logic idx, logic [7:0] data);
         if (idx == arwc_pkg::CSR_ENABLE) enable = data[0];
         else min_length = data;
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("%s", what);
      endfunction

      function void note_packet(arwc_pkg::req_payload_type pkt);
         logic [63:0] behind_by;
         logic [63:0] shift;
         logic [63:0] bit_sel;
         logic [63:0] next_map;
         logic [63:0] next_high;
         logic [31:0] next_good;
         logic [31:0] next_late;
         logic [31:0] next_lost;
         logic [2:0]  verdict;
         arwc_pkg::rsp_payload_type want;
         next_map  = seen_map;
         next_high = highest;
         next_good = good_total;
         next_late = late_total;
         next_lost = lost_total;
         if (!enable || pkt.packet_length < {8'd0, min_length}) begin
            verdict = arwc_pkg::ST_SHORT;
         end else if (pkt.packet_counter <= highest) begin
            behind_by = highest - pkt.packet_counter;
            if (behind_by >= arwc_pkg::WINDOW_LEN) begin
               verdict = arwc_pkg::ST_OLD;
            end else begin
               bit_sel = arwc_pkg::TOP_BIT >> behind_by;
               if ((seen_map & bit_sel) != '0) begin
                  verdict = arwc_pkg::ST_DUP;
               end else begin
                  next_map  = seen_map | bit_sel;
                  next_late = late_total + 32'd1;
                  verdict   = arwc_pkg::ST_LATE;
               end
            end
         end else begin
            shift = pkt.packet_counter - highest;
            if (shift >= arwc_pkg::WINDOW_LEN) begin
               // big jump: only the newest counter survives
               next_map = arwc_pkg::TOP_BIT;
               shift    = arwc_pkg::WINDOW_LEN;
            end else begin
               next_map = ((seen_map << shift) | arwc_pkg::TOP_BIT) & arwc_pkg::WINDOW_MASK;
            end
            next_high = pkt.packet_counter;
            next_lost = lost_total + 32'(shift - 64'd1);
            next_good = good_total + 32'd1;
            verdict   = arwc_pkg::ST_NEW;
         end
         if ((verdict == arwc_pkg::ST_NEW || verdict == arwc_pkg::ST_LATE) && !pkt.auth_ok)
            verdict = arwc_pkg::ST_AUTH;
         if (verdict == arwc_pkg::ST_NEW || verdict == arwc_pkg::ST_LATE) begin
            highest    = next_high;
            seen_map   = next_map;
            good_total = next_good;
            late_total = next_late;
            lost_total = next_lost;
            want.accepted = 1'b1;
         end else begin
            want.accepted = 1'b0;
         end
         want.status     = verdict;
         want.good_count = good_total;
         want.late_count = late_total;
         want.lost_count = lost_total;
         status_hits[verdict]++;
         expected_q.push_back(want);
      endfunction

      function void check_result(arwc_pkg::rsp_payload_type got);
         arwc_pkg::rsp_payload_type want;
         if (expected_q.size() == 0) begin
            flag($sformatf("unexpected result beat: acc=%0b st=%0d good=%0d late=%0d lost=%0d",
                           got.accepted, got.status, got.good_count, got.late_count,
                           got.lost_count));
            return;
         end
         want = expected_q.pop_front();
         if (got.accepted !== want.accepted || got.status !== want.status ||
             got.good_count !== want.good_count || got.late_count !== want.late_count ||
             got.lost_count !== want.lost_count)
            flag($sformatf({"result %0d mismatch: expected acc=%0b st=%0d good=%0d late=%0d",
                            " lost=%0d, got acc=%0b st=%0d good=%0d late=%0d lost=%0d"},
                           results_checked, want.accepted, want.status, want.good_count,
                           want.late_count, want.lost_count, got.accepted, got.status,
                           got.good_count, got.late_count, got.lost_count));
         results_checked++;
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   arwc_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   arwc_pkg::rsp_payload_type rsp_payload;
   logic                      csr_wr_en = 1'b0;
   logic                      csr_index = arwc_pkg::CSR_ENABLE;
   logic [7:0]                csr_wdata = '0;

   replay_scoreboard sb = new();

   // stimulus-side view of the window, used only to aim the next counter
   logic [63:0] guide_high = '0;
   logic        cur_enable = 1'b0;
   logic [7:0]  cur_min = arwc_pkg::MIN_LENGTH_RESET;
   int          idle_pct = 25;
   int          rx_hold_len = 0;
   int          settings_used = 1;
   int          sent_count = 0;

   anti_replay_window_check_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_packet(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
      end
   end

   // Receiver: random stalls, or one long hold-off when requested.
   initial begin
      forever begin
         @(posedge clock);
         if (rx_hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (rx_hold_len) @(posedge clock);
            rx_hold_len = 0;
         end else begin
            rsp_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic arwc_pkg::req_payload_type build_packet(logic [63:0] ctr,
                                                              logic [15:0] len,
                                                              logic auth);
      arwc_pkg::req_payload_type pkt;
      pkt.packet_counter = ctr;
      pkt.packet_length  = len;
      pkt.auth_ok        = auth;
      return pkt;
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 16'($urandom_range(int'(cur_min) + 1400, int'(cur_min)));
      if (r < 85 || cur_min == 8'd0) return 16'($urandom_range(65535));
      return 16'($urandom_range(int'(cur_min) - 1, 0));
   endfunction

   function automatic arwc_pkg::req_payload_type make_packet();
      logic [63:0] ctr;
      logic [63:0] back;
      logic        auth;
      int          r;
      r    = $urandom_range(99);
      auth = ($urandom_range(99) >= 8);
      if (r < 40) begin
         ctr = guide_high + 64'($urandom_range(3, 1));
      end else if (r < 52) begin
         ctr = guide_high + 64'($urandom_range(63, 4));
      end else if (r < 56) begin
         ctr = guide_high + 64'($urandom_range(100000, 64));
      end else if (r < 80) begin
         // aim inside the window, a third of these at the four newest counters to hit duplicates
         back = (r < 72) ? 64'($urandom_range(63, 0)) : 64'($urandom_range(3, 0));
         if (back > guide_high) back = guide_high;
         ctr = guide_high - back;
      end else if (r < 88 && guide_high >= 64'd64) begin
         back = 64'($urandom_range(5000, 64));
         if (back > guide_high) back = guide_high;
         ctr = guide_high - back;
      end else begin
         // full-range counter; keep auth low so the window is not dragged away
         ctr  = {$urandom, $urandom};
         auth = 1'b0;
      end
      return build_packet(ctr, pick_length(), auth);
   endfunction

   task automatic offer_packet(input arwc_pkg::req_payload_type pkt);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(posedge clock);
      end
      if (cur_enable && pkt.packet_length >= {8'd0, cur_min} && pkt.auth_ok &&
          pkt.packet_counter > guide_high)
         guide_high = pkt.packet_counter;
      req_valid   <= 1'b1;
      req_payload <= pkt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.results_checked != sent_count) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      if (idx == arwc_pkg::CSR_ENABLE) cur_enable = data[0];
      else cur_min = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic en, input logic [7:0] min_len, input int n_items,
                            input int idle, input int hold_len);
      drain();
      csr_write(arwc_pkg::CSR_ENABLE, {7'($urandom_range(127)), en});
      csr_write(arwc_pkg::CSR_MIN_LENGTH, min_len);
      settings_used++;
      // back-to-back beats while the receiver holds off fill the pipeline
      idle_pct    = (hold_len > 0) ? 0 : idle;
      rx_hold_len = hold_len;
      for (int i = 0; i < n_items; i++) begin
         if (i == 30) idle_pct = idle;
         offer_packet(make_packet());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: disabled after reset, then window corner cases
      offer_packet(build_packet(64'd7, 16'd100, 1'b1));
      drain();
      csr_write(arwc_pkg::CSR_ENABLE, 8'h01);
      offer_packet(build_packet(64'd0, 16'd27, 1'b1));
      offer_packet(build_packet(64'd0, 16'd28, 1'b1));
      offer_packet(build_packet(64'd0, 16'd40, 1'b1));
      offer_packet(build_packet(64'd1, 16'd60, 1'b0));
      offer_packet(build_packet(64'd1, 16'd60, 1'b1));
      offer_packet(build_packet(64'd1, 16'd60, 1'b0));
      offer_packet(build_packet(64'd5, 16'd60, 1'b1));
      offer_packet(build_packet(64'd3, 16'd60, 1'b1));
      offer_packet(build_packet(64'd3, 16'd60, 1'b1));
      offer_packet(build_packet(64'd68, 16'd60, 1'b1));
      offer_packet(build_packet(64'd5, 16'd60, 1'b1));
      offer_packet(build_packet(64'd4, 16'd60, 1'b1));
      offer_packet(build_packet(64'd132, 16'd60, 1'b1));
      offer_packet(build_packet(64'd1132, 16'd1500, 1'b1));
      offer_packet(build_packet(64'd1100, 16'd60, 1'b0));
      offer_packet(build_packet(64'd1100, 16'hFFFF, 1'b1));

      run_phase(1'b1, 8'd28, 300, 25, 0);
      run_phase(1'b1, 8'd0, 250, 0, 0);
      run_phase(1'b1, 8'd255, 250, 25, 60);
      run_phase(1'b0, 8'd100, 60, 25, 0);
      run_phase(1'b1, 8'($urandom_range(254, 1)), 300, 25, 0);
      run_phase(1'b1, 8'd28, 500, 25, 0);

      // top of the counter range last: nothing can move past it afterward
      offer_packet(build_packet(64'hFFFF_FFFF_FFFF_FFFE, 16'd100, 1'b1));
      offer_packet(build_packet(64'hFFFF_FFFF_FFFF_FFFF, 16'd100, 1'b1));
      offer_packet(build_packet(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1));
      offer_packet(build_packet(64'hFFFF_FFFF_FFFF_FFC0, 16'd100, 1'b1));
      offer_packet(build_packet(64'hFFFF_FFFF_FFFF_FFBF, 16'd100, 1'b1));
      offer_packet(build_packet(64'd0, 16'd100, 1'b1));

      req_valid <= 1'b0;
      while (sb.results_checked != sent_count) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.flag($sformatf("%0d expected results never arrived", sb.expected_q.size()));

      $display("Covered %0d packet beats under %0d register settings: new %0d, late %0d,",
               sb.results_checked, settings_used, sb.status_hits[arwc_pkg::ST_NEW],
               sb.status_hits[arwc_pkg::ST_LATE]);
      $display("short/disabled %0d, too old %0d, duplicate %0d, auth failed %0d; %0d mismatches",
               sb.status_hits[arwc_pkg::ST_SHORT], sb.status_hits[arwc_pkg::ST_OLD],
               sb.status_hits[arwc_pkg::ST_DUP], sb.status_hits[arwc_pkg::ST_AUTH],
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
